### design/mpt_pkg.sv
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared constants and controller/datapath interface types for the
// Lucas-Lehmer Mersenne prime tester.
// ----------------------------------------------------------------------------
`default_nettype none

package mpt_pkg;

  // exponent field width, fixed by the word format
  localparam int EXP_W   = 5;
  // largest exponent tested; larger ones answer not prime
  localparam int MAX_EXP = 31;
  // residue width, enough for 2^MAX_EXP - 1
  localparam int RES_W   = MAX_EXP;
  // squared residue width
  localparam int PROD_W  = 2 * RES_W;

  // stream word widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture exponent, set residue to four, set loop count
    logic mul;    // register the square of the residue
    logic fold;   // reduce modulo M, subtract two, count down
    logic emit;   // write the answer to the output register
  } mpt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic exp_ok;  // incoming exponent lies in the supported range
    logic last;    // the current squaring is the final one
  } mpt_status_t;

endpackage

`default_nettype wire

### design/mpt_dp.sv
// ----------------------------------------------------------------------------
// mpt_dp
// Datapath: residue register, one squarer, a Mersenne fold unit, the loop
// counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_dp (
  input  wire                      clk,
  input  wire  [mpt_pkg::EXP_W-1:0] exponent,
  input  wire  mpt_pkg::mpt_cmd_t   cmd,
  output mpt_pkg::mpt_status_t      status,
  output logic                      is_prime
);
  import mpt_pkg::*;

  logic [EXP_W-1:0]  p;
  logic              ok;
  logic [EXP_W-1:0]  count;
  logic [RES_W-1:0]  s;
  logic [PROD_W-1:0] prod;

  logic [RES_W-1:0]  one_sh;
  logic [RES_W-1:0]  m;
  logic [RES_W-1:0]  hi_full;
  logic [RES_W:0]    fold_sum;
  logic [RES_W-1:0]  red;
  logic [RES_W-1:0]  s_next;
  logic              exp_ok_in;

  // range check on the incoming exponent
  assign exp_ok_in = (int'(exponent) >= 3) && (int'(exponent) <= MAX_EXP);

  // modulus M = 2^p - 1, the shift wraps to zero when p is the full width
  assign one_sh = RES_W'(1) << p;
  assign m      = one_sh - RES_W'(1);

  // fold: low p bits plus the bits above them, then one conditional subtract
  assign hi_full  = RES_W'(prod >> p);
  assign fold_sum = {1'b0, prod[RES_W-1:0] & m} + {1'b0, hi_full};
  assign red      = RES_W'((fold_sum >= {1'b0, m}) ? fold_sum - {1'b0, m} : fold_sum);

  // subtract two modulo M
  assign s_next = (red >= RES_W'(2)) ? red - RES_W'(2) : red + m - RES_W'(2);

  assign status.exp_ok = exp_ok_in;
  assign status.last   = (count == EXP_W'(1));

  // residue, counter and product registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p     <= exponent;
      ok    <= exp_ok_in;
      count <= exponent - EXP_W'(2);
      s     <= RES_W'(4);
    end
    if (cmd.mul) begin
      prod <= s * s;
    end
    if (cmd.fold) begin
      s     <= s_next;
      count <= count - EXP_W'(1);
    end
    if (cmd.emit) begin
      is_prime <= ok && (s == '0);
    end
  end

endmodule

`default_nettype wire

### design/mpt_ctrl.sv
// ----------------------------------------------------------------------------
// mpt_ctrl
// Controller: sequences load, square and fold steps for one exponent and
// owns the handshake of both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  wire  mpt_pkg::mpt_status_t status,
  output mpt_pkg::mpt_cmd_t    cmd
);
  import mpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FOLD = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.exp_ok ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = status.last ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### design/mersenne_prime_test.sv
// ----------------------------------------------------------------------------
// mersenne_prime_test
// Lucas-Lehmer test of 2^p - 1: one exponent word in, one prime flag word out.
// ----------------------------------------------------------------------------
//  channel  | direction | fields (lsb up)
//  s_axis   | in        | tdata: exponent[4:0], zero pad
//  m_axis   | out       | tdata: is_prime[0], zero pad
//
//  An exponent p in range runs p-2 steps between acceptance and the result
//  word: each step passes the residue through the squarer and then through
//  the fold and subtract unit. Exponents out of range skip the steps.
//  One exponent is worked on at a time; a new word is taken while the last
//  result still waits in the output register. Reset is synchronous and
//  clears the controller only. A stalled output holds the controller in its
//  final state until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_prime_test (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [mpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // exponent[4:0], pad
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [mpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // is_prime[0], pad
);
  import mpt_pkg::*;

  mpt_cmd_t    cmd;
  mpt_status_t status;
  logic        is_prime;

  // sequencing and handshake
  mpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // residue arithmetic
  mpt_dp u_dp (
    .clk      (clk),
    .exponent (s_axis_tdata[EXP_W-1:0]),
    .cmd      (cmd),
    .status   (status),
    .is_prime (is_prime)
  );

  // pack the result word
  assign m_axis_tdata = {(OUT_TDATA_W - 1)'(0), is_prime};

endmodule

`default_nettype wire

### test/mersenne_prime_checker.sv
// ----------------------------------------------------------------------------
// mersenne_prime_checker
// Watches both stream channels of the Mersenne prime tester. Each accepted
// exponent word yields a predicted prime flag from its own Lucas-Lehmer run.
// Each result word is matched in order against the oldest waiting flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mersenne_prime_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  input  wire                                s_axis_tready,
  input  wire  [mpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // exponent[4:0], pad
  input  wire                                m_axis_tvalid,
  input  wire                                m_axis_tready,
  input  wire  [mpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // is_prime[0], pad
  output int                                 failures,
  output int                                 outstanding,
  output int                                 checked,
  output int                                 primes_seen
);

  // prime flags still owed by the block, oldest first
  bit verdicts_due[$];

  // lucas-lehmer run on 2^p - 1, residues kept in 0..M-1
  function automatic bit lucas_lehmer_verdict(input logic [mpt_pkg::EXP_W-1:0] p);
    logic [63:0] modulus;
    logic [63:0] residue;
    logic [63:0] square;
    int          k;
    if (p < 3 || p > mpt_pkg::MAX_EXP) return 1'b0;
    modulus = (64'd1 << p) - 64'd1;
    residue = 64'd4;
    for (k = 0; k < int'(p) - 2; k++) begin
      // residue below 2^31, so the square fits in 64 bits
      square  = (residue * residue) % modulus;
      residue = (square >= 64'd2) ? square - 64'd2 : square + modulus - 64'd2;
    end
    return residue == 64'd0;
  endfunction

  initial begin
    failures    = 0;
    outstanding = 0;
    checked     = 0;
    primes_seen = 0;
  end

  // outputs sampled before the edge updates them; result side first, since a
  // result can never belong to a word accepted at the same edge
  always @(posedge clk) begin
    bit due;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result word: is_prime actual %0d", m_axis_tdata[0]);
          failures++;
        end else begin
          due = verdicts_due.pop_front();
          if (m_axis_tdata[0] !== due) begin
            $error("is_prime mismatch: expected %0d, actual %0d", due, m_axis_tdata[0]);
            failures++;
          end
          checked++;
          if (due) primes_seen++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        verdicts_due.push_back(lucas_lehmer_verdict(s_axis_tdata[mpt_pkg::EXP_W-1:0]));
      outstanding = verdicts_due.size();
    end
  end

endmodule

### test/tb_mersenne_prime_test.sv
// ----------------------------------------------------------------------------
// tb_mersenne_prime_test
// Drives exponent words into the Mersenne prime tester under several idle and
// stall patterns, a long output hold and a drain pause. The checker beside
// the block predicts and compares each prime flag; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mersenne_prime_test;

  localparam int RANDOM_PER_PHASE = 150;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 70;

  logic                              clk;
  logic                              rst;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [mpt_pkg::IN_TDATA_W-1:0]    s_axis_tdata;    // exponent[4:0], pad
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [mpt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;    // is_prime[0], pad

  int failures;
  int outstanding;
  int checked;
  int primes_seen;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int words_sent;

  // exponents whose Mersenne number is prime, favored in the random part
  logic [mpt_pkg::EXP_W-1:0] prime_exponents[7] = '{3, 5, 7, 13, 17, 19, 31};
  logic [mpt_pkg::EXP_W-1:0] directed_exponents[20] =
    '{0, 1, 2, 3, 31, 4, 5, 7, 13, 17, 19, 11, 23, 29, 9, 15, 30, 16, 6, 8};

  mersenne_prime_test DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mersenne_prime_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .failures      (failures),
    .outstanding   (outstanding),
    .checked       (checked),
    .primes_seen   (primes_seen)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("run limit reached with %0d results outstanding", outstanding);
    $display("[mersenne_prime_test] ERROR");
    $finish;
  end

  // receiver: random stalls, plus a long counted hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one exponent word at the falling edge, return once it is taken
  task automatic send_exponent(input logic [mpt_pkg::EXP_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(mpt_pkg::IN_TDATA_W - mpt_pkg::EXP_W){1'b0}}, p};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    words_sent++;
  endtask

  // random exponent, one in four from the prime list
  function automatic logic [mpt_pkg::EXP_W-1:0] pick_exponent();
    if ($urandom_range(3) == 0) return prime_exponents[3'($urandom_range(6))];
    return mpt_pkg::EXP_W'($urandom_range(31));
  endfunction

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int phase;
    int n;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    words_sent     = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed: range ends, undefined low exponents, prime and composite M
    foreach (directed_exponents[i]) send_exponent(directed_exponents[i]);

    // sender pauses until every flag is back
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long output hold while words keep coming, so the input backs up
        if (phase == 0 && n == 50) hold_request = 1'b1;
        send_exponent(pick_exponent());
      end
      if (phase == 1) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d exponent words, %0d results checked, %0d of them prime",
             words_sent, checked, primes_seen);
    $display("phases: no idling, sender gaps, receiver stalls, both; one long hold");
    if (failures == 0) begin
      $display("[mersenne_prime_test] OK");
    end else begin
      $display("[mersenne_prime_test] ERROR");
    end
    $finish;
  end

endmodule

### mersenne_prime_test.f
design/mpt_pkg.sv
design/mpt_dp.sv
design/mpt_ctrl.sv
design/mersenne_prime_test.sv
test/mersenne_prime_checker.sv
test/tb_mersenne_prime_test.sv
